// ===== rtl/core/assert_macros.svh =====
// Assertion helpers, sampled on clk and held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bsmeb_pkg.sv =====
package bsmeb_pkg;

  localparam int NODES_DEF         = 256;
  localparam int MAX_NEIGHBORS_DEF = 64;

  localparam int BANDS    = 5;
  localparam int STUB_W   = 4;
  localparam int BAND_W   = 3;
  localparam int NODE_W   = 8;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 4;
  localparam int DEG_W    = 7;
  localparam int LEFT_W   = 7;
  localparam int EDGE_W   = 14;

  // Request layout: node, other, band, five stub counts, one pad bit.
  localparam int IN_NODE_LSB  = 0;
  localparam int IN_OTHER_LSB = IN_NODE_LSB + NODE_W;
  localparam int IN_BAND_LSB  = IN_OTHER_LSB + NODE_W;
  localparam int IN_STUB_LSB  = IN_BAND_LSB + BAND_W;
  localparam int IN_DATA_W    = 40;
  localparam int OUT_DATA_W   = STATUS_W + NODE_W + DEG_W + LEFT_W + EDGE_W;

  localparam logic [FUNC_W-1:0] FN_LOAD = 2'd0;
  localparam logic [FUNC_W-1:0] FN_TRY  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_READ = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED           = 4'd0,
    ST_SITE_EXHAUSTED  = 4'd1,
    ST_LINKED          = 4'd2,
    ST_PARTNER_NO_STUB = 4'd3,
    ST_SITE_NO_STUB    = 4'd4,
    ST_SELF            = 4'd5,
    ST_FULL            = 4'd6,
    ST_OK              = 4'd7,
    ST_BAD_INDEX       = 4'd8
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_RD_REC,
    S_RD_NB,
    S_TRY_SITE,
    S_TRY_PART,
    S_SCAN,
    S_CHECK,
    S_LINK_SITE,
    S_LINK_PART,
    S_RESULT
  } state_t;

  typedef logic [BANDS-1:0][STUB_W-1:0] stub_vec_t;

  typedef struct packed {
    stub_vec_t         stubs;
    logic [BAND_W-1:0] band;
  } node_rec_t;

  localparam int NODE_REC_W = $bits(node_rec_t);

  function automatic logic [LEFT_W-1:0] stub_total(input stub_vec_t s);
    logic [LEFT_W-1:0] acc;
    acc = '0;
    for (int b = 0; b < BANDS; b++) begin
      acc = acc + LEFT_W'(s[b]);
    end
    return acc;
  endfunction

  function automatic logic [STUB_W-1:0] stub_pick(input stub_vec_t s,
                                                  input logic [BAND_W-1:0] band);
    logic [STUB_W-1:0] r;
    r = '0;
    for (int b = 0; b < BANDS; b++) begin
      if (BAND_W'(b) == band) begin
        r = s[b];
      end
    end
    return r;
  endfunction

  // Take one stub from the given band.
  function automatic stub_vec_t stub_take(input stub_vec_t s,
                                          input logic [BAND_W-1:0] band);
    stub_vec_t r;
    r = s;
    for (int b = 0; b < BANDS; b++) begin
      if (BAND_W'(b) == band) begin
        r[b] = s[b] - STUB_W'(1);
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/banded_stub_matching_edge_builder.sv =====
// Banded stub-matching edge builder. Each request is a load (set a node's band and
// five stub counts, empty its neighbor list), a try (link a site to a partner if
// both have matching stubs, they differ, are not yet linked and have list room) or
// a read (return one neighbor by index); every request gives one result. Requests
// run one at a time. The scan for an existing link reads the neighbor memory one
// entry per cycle and compares each entry in the cycle after its read. A try
// turned down early skips the scan. A stalled output holds the block in its
// result state, so the next request waits. Node records (band, stubs, count)
// sit in one memory and neighbor lists in a second, both with one write and one
// registered read port. After reset the block zeroes the node record memory,
// one node per cycle, and holds in_tready low until that pass is done. A
// finished result waits in the output register while the next request is taken.
`include "assert_macros.svh"

module banded_stub_matching_edge_builder #(
  parameter int NODES         = bsmeb_pkg::NODES_DEF,
  parameter int MAX_NEIGHBORS = bsmeb_pkg::MAX_NEIGHBORS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // node[7:0], other[15:8], band[18:16], stubs_band0[22:19], stubs_band1[26:23],
  // stubs_band2[30:27], stubs_band3[34:31], stubs_band4[38:35], zero[39]
  input  logic [bsmeb_pkg::IN_DATA_W-1:0]  in_tdata,
  // func[1:0]
  input  logic [bsmeb_pkg::FUNC_W-1:0]     in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // status[3:0], neighbor_out[11:4], degree_out[18:12], stubs_left[25:19],
  // edge_total[39:26]
  output logic [bsmeb_pkg::OUT_DATA_W-1:0] out_tdata
);

  import bsmeb_pkg::*;

  localparam int NW    = $clog2(NODES);
  localparam int CW    = $clog2(MAX_NEIGHBORS + 1);
  localparam int IW    = $clog2(MAX_NEIGHBORS);
  localparam int NBD   = NODES * MAX_NEIGHBORS;
  localparam int NBAW  = $clog2(NBD);
  localparam int REC_W = NODE_REC_W + CW;

  // Control registers
  state_t              state_r,   state_nxt;
  logic [NW-1:0]       clr_idx_r, clr_idx_nxt;
  logic [EDGE_W-1:0]   edge_cnt_r, edge_cnt_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic                out_tvalid_r;

  // Request and working registers
  logic [FUNC_W-1:0]   req_func_r,  req_func_nxt;
  logic [NODE_W-1:0]   req_node_r,  req_node_nxt;
  logic [NODE_W-1:0]   req_other_r, req_other_nxt;
  logic [BAND_W-1:0]   req_band_r,  req_band_nxt;
  stub_vec_t           req_stubs_r, req_stubs_nxt;
  logic [NBAW-1:0]     site_base_r, site_base_nxt;
  logic [NBAW-1:0]     part_base_r, part_base_nxt;
  node_rec_t           site_rec_r,  site_rec_nxt;
  logic [CW-1:0]       site_cnt_r,  site_cnt_nxt;
  node_rec_t           part_rec_r,  part_rec_nxt;
  logic [CW-1:0]       part_cnt_r,  part_cnt_nxt;
  logic [CW-1:0]       scan_k_r,    scan_k_nxt;
  logic                found_r,     found_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [NODE_W-1:0]   res_nb_r,    res_nb_nxt;
  logic [DEG_W-1:0]    res_deg_r,   res_deg_nxt;
  logic [LEFT_W-1:0]   res_left_r,  res_left_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic                load_out;

  // Memory ports
  logic                rec_we;
  logic [NW-1:0]       rec_waddr, rec_raddr;
  logic [REC_W-1:0]    rec_wdata, rec_rdata;
  logic                nb_we;
  logic [NBAW-1:0]     nb_waddr, nb_raddr;
  logic [NODE_W-1:0]   nb_wdata, nb_rdata;

  // Decoded views
  node_rec_t           rd_rec;
  logic [CW-1:0]       rd_cnt;
  stub_vec_t           in_stubs;
  logic [NW-1:0]       site_idx, part_idx;
  logic                node_ok, other_ok;
  logic [BAND_W-1:0]   band_sat;

  bsmeb_ram #(
    .WIDTH (REC_W),
    .DEPTH (NODES)
  ) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .raddr (rec_raddr),
    .rdata (rec_rdata)
  );

  bsmeb_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NBD)
  ) u_nb_ram (
    .clk   (clk),
    .we    (nb_we),
    .waddr (nb_waddr),
    .wdata (nb_wdata),
    .raddr (nb_raddr),
    .rdata (nb_rdata)
  );

  assign rd_rec   = node_rec_t'(rec_rdata[NODE_REC_W-1:0]);
  assign rd_cnt   = rec_rdata[REC_W-1 -: CW];
  assign site_idx = NW'(req_node_r);
  assign part_idx = NW'(req_other_r);
  assign node_ok  = 32'(req_node_r) < NODES;
  assign other_ok = 32'(req_other_r) < NODES;
  assign band_sat = (req_band_r > BAND_W'(BANDS - 1)) ? BAND_W'(BANDS - 1) : req_band_r;

  always_comb begin
    for (int b = 0; b < BANDS; b++) begin
      in_stubs[b] = in_tdata[IN_STUB_LSB + b*STUB_W +: STUB_W];
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    edge_cnt_nxt   = edge_cnt_r;
    cmp_vld_nxt    = cmp_vld_r;
    req_func_nxt   = req_func_r;
    req_node_nxt   = req_node_r;
    req_other_nxt  = req_other_r;
    req_band_nxt   = req_band_r;
    req_stubs_nxt  = req_stubs_r;
    site_base_nxt  = site_base_r;
    part_base_nxt  = part_base_r;
    site_rec_nxt   = site_rec_r;
    site_cnt_nxt   = site_cnt_r;
    part_rec_nxt   = part_rec_r;
    part_cnt_nxt   = part_cnt_r;
    scan_k_nxt     = scan_k_r;
    found_nxt      = found_r;
    res_status_nxt = res_status_r;
    res_nb_nxt     = res_nb_r;
    res_deg_nxt    = res_deg_r;
    res_left_nxt   = res_left_r;
    load_out       = 1'b0;
    rec_we         = 1'b0;
    rec_waddr      = site_idx;
    rec_wdata      = '0;
    rec_raddr      = site_idx;
    nb_we          = 1'b0;
    nb_waddr       = '0;
    nb_wdata       = '0;
    nb_raddr       = '0;

    unique case (state_r)
      S_CLEAR: begin
        rec_we      = 1'b1;
        rec_waddr   = clr_idx_r;
        clr_idx_nxt = clr_idx_r + NW'(1);
        if (clr_idx_r == NW'(NODES - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_tvalid) begin
          req_func_nxt  = in_tuser;
          req_node_nxt  = in_tdata[IN_NODE_LSB +: NODE_W];
          req_other_nxt = in_tdata[IN_OTHER_LSB +: NODE_W];
          req_band_nxt  = in_tdata[IN_BAND_LSB +: BAND_W];
          req_stubs_nxt = in_stubs;
          site_base_nxt = NBAW'(32'(NW'(in_tdata[IN_NODE_LSB +: NODE_W])) * MAX_NEIGHBORS);
          part_base_nxt = NBAW'(32'(NW'(in_tdata[IN_OTHER_LSB +: NODE_W])) * MAX_NEIGHBORS);
          state_nxt     = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        res_status_nxt = ST_BAD_INDEX;
        res_nb_nxt     = '0;
        res_deg_nxt    = '0;
        res_left_nxt   = '0;
        state_nxt      = S_RESULT;
        unique case (req_func_r)
          FN_LOAD: begin
            if (node_ok) begin
              rec_we         = 1'b1;
              rec_wdata      = {CW'(0), req_stubs_r, band_sat};
              res_status_nxt = ST_OK;
              res_left_nxt   = stub_total(req_stubs_r);
            end
          end
          FN_TRY: begin
            if (node_ok && other_ok) begin
              state_nxt = S_TRY_SITE;
            end
          end
          FN_READ: begin
            if (node_ok) begin
              state_nxt = S_RD_REC;
            end
          end
          default: begin
            state_nxt = S_RESULT;
          end
        endcase
      end

      S_RD_REC: begin
        site_rec_nxt = rd_rec;
        site_cnt_nxt = rd_cnt;
        res_deg_nxt  = DEG_W'(rd_cnt);
        res_left_nxt = stub_total(rd_rec.stubs);
        if (32'(req_other_r) < 32'(rd_cnt)) begin
          nb_raddr  = site_base_r + NBAW'(IW'(req_other_r));
          state_nxt = S_RD_NB;
        end else begin
          res_status_nxt = ST_BAD_INDEX;
          state_nxt      = S_RESULT;
        end
      end

      S_RD_NB: begin
        res_status_nxt = ST_OK;
        res_nb_nxt     = nb_rdata;
        state_nxt      = S_RESULT;
      end

      S_TRY_SITE: begin
        site_rec_nxt = rd_rec;
        site_cnt_nxt = rd_cnt;
        rec_raddr    = part_idx;
        state_nxt    = S_TRY_PART;
      end

      S_TRY_PART: begin
        part_rec_nxt = rd_rec;
        part_cnt_nxt = rd_cnt;
        res_deg_nxt  = DEG_W'(site_cnt_r);
        res_left_nxt = stub_total(site_rec_r.stubs);
        scan_k_nxt   = '0;
        cmp_vld_nxt  = 1'b0;
        found_nxt    = 1'b0;
        if (stub_total(site_rec_r.stubs) == '0) begin
          res_status_nxt = ST_SITE_EXHAUSTED;
          state_nxt      = S_RESULT;
        end else if (req_node_r == req_other_r) begin
          res_status_nxt = ST_SELF;
          state_nxt      = S_RESULT;
        end else begin
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        // Issue one list read per cycle, compare the one issued in the previous cycle.
        if (scan_k_r != site_cnt_r) begin
          nb_raddr    = site_base_r + NBAW'(IW'(scan_k_r));
          scan_k_nxt  = scan_k_r + CW'(1);
          cmp_vld_nxt = 1'b1;
        end else begin
          cmp_vld_nxt = 1'b0;
        end
        if (cmp_vld_r && (nb_rdata == req_other_r)) begin
          found_nxt = 1'b1;
        end
        if ((scan_k_r == site_cnt_r) && !cmp_vld_r) begin
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        state_nxt = S_RESULT;
        if (found_r) begin
          res_status_nxt = ST_LINKED;
        end else if (stub_pick(part_rec_r.stubs, site_rec_r.band) == '0) begin
          res_status_nxt = ST_PARTNER_NO_STUB;
        end else if (stub_pick(site_rec_r.stubs, part_rec_r.band) == '0) begin
          res_status_nxt = ST_SITE_NO_STUB;
        end else if (site_cnt_r >= CW'(MAX_NEIGHBORS) ||
                     part_cnt_r >= CW'(MAX_NEIGHBORS)) begin
          res_status_nxt = ST_FULL;
        end else begin
          state_nxt = S_LINK_SITE;
        end
      end

      S_LINK_SITE: begin
        nb_we          = 1'b1;
        nb_waddr       = site_base_r + NBAW'(IW'(site_cnt_r));
        nb_wdata       = req_other_r;
        rec_we         = 1'b1;
        rec_waddr      = site_idx;
        rec_wdata      = {site_cnt_r + CW'(1),
                          stub_take(site_rec_r.stubs, part_rec_r.band), site_rec_r.band};
        res_status_nxt = ST_ADDED;
        res_deg_nxt    = DEG_W'(site_cnt_r + CW'(1));
        res_left_nxt   = stub_total(site_rec_r.stubs) - LEFT_W'(1);
        state_nxt      = S_LINK_PART;
      end

      S_LINK_PART: begin
        nb_we     = 1'b1;
        nb_waddr  = part_base_r + NBAW'(IW'(part_cnt_r));
        nb_wdata  = req_node_r;
        rec_we    = 1'b1;
        rec_waddr = part_idx;
        rec_wdata = {part_cnt_r + CW'(1),
                     stub_take(part_rec_r.stubs, site_rec_r.band), part_rec_r.band};
        if (edge_cnt_r != '1) begin
          edge_cnt_nxt = edge_cnt_r + EDGE_W'(1);
        end
        state_nxt = S_RESULT;
      end

      S_RESULT: begin
        // Hold until the output register is free.
        if (!out_tvalid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_idx_r    <= '0;
      edge_cnt_r   <= '0;
      cmp_vld_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_idx_r  <= clr_idx_nxt;
      edge_cnt_r <= edge_cnt_nxt;
      cmp_vld_r  <= cmp_vld_nxt;
      if (load_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_func_r   <= req_func_nxt;
    req_node_r   <= req_node_nxt;
    req_other_r  <= req_other_nxt;
    req_band_r   <= req_band_nxt;
    req_stubs_r  <= req_stubs_nxt;
    site_base_r  <= site_base_nxt;
    part_base_r  <= part_base_nxt;
    site_rec_r   <= site_rec_nxt;
    site_cnt_r   <= site_cnt_nxt;
    part_rec_r   <= part_rec_nxt;
    part_cnt_r   <= part_cnt_nxt;
    scan_k_r     <= scan_k_nxt;
    found_r      <= found_nxt;
    res_status_r <= res_status_nxt;
    res_nb_r     <= res_nb_nxt;
    res_deg_r    <= res_deg_nxt;
    res_left_r   <= res_left_nxt;
    if (load_out) begin
      out_tdata_r <= {edge_cnt_r, res_left_r, res_deg_r, res_nb_r, res_status_r};
    end
  end

  `ASSERT_IMPL(a_scan_bound, state_r == S_SCAN, scan_k_r <= site_cnt_r, "scan index past site count")
  `ASSERT_NEXT(a_edge_mono, 1'b1, edge_cnt_r >= $past(edge_cnt_r), "edge count went down")
  `ASSERT_IMPL(a_link_room, state_r == S_LINK_SITE, (site_cnt_r < CW'(MAX_NEIGHBORS)) && (part_cnt_r < CW'(MAX_NEIGHBORS)) && (req_node_r != req_other_r), "link without room or to self")

endmodule

// ===== rtl/core/bsmeb_ram.sv =====
module bsmeb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
